[rtl/base_relocation_fixup_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the relocation fixup core.
// ---------------------------------------------------------------------------
`ifndef BASE_RELOCATION_FIXUP_CORE_ASSERT_SVH
`define BASE_RELOCATION_FIXUP_CORE_ASSERT_SVH

// Checked only while reset is released.
`define BRF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/brf_pkg.sv]
// ---------------------------------------------------------------------------
// brf_pkg
// Types and codes shared by the relocation fixup core and its checker.
// ---------------------------------------------------------------------------
package brf_pkg;

  typedef logic signed [32:0] delta_t;
  typedef logic [1:0]         wr_width_t;
  typedef logic [1:0]         status_t;
  typedef logic [3:0]         rel_type_t;

  localparam wr_width_t WW_NONE = 2'd0;
  localparam wr_width_t WW_HALF = 2'd1;
  localparam wr_width_t WW_WORD = 2'd2;

  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_UNKNOWN    = 2'd1;
  localparam status_t ST_NO_PARTNER = 2'd2;

  localparam rel_type_t RT_ABSOLUTE = 4'd0;
  localparam rel_type_t RT_HIGH     = 4'd1;
  localparam rel_type_t RT_LOW      = 4'd2;
  localparam rel_type_t RT_HIGHLOW  = 4'd3;
  localparam rel_type_t RT_HIGHADJ  = 4'd4;

  localparam int          TYPE_SHIFT  = 12;
  localparam logic [11:0] OFFSET_MASK = 12'hfff;
  localparam logic [31:0] ROUND_HALF  = 32'h0000_8000;

endpackage

[rtl/base_relocation_fixup_core.sv]
// ---------------------------------------------------------------------------
// base_relocation_fixup_core
// Applies the image base delta to one relocation entry per word and emits
// the patch to write back, if any, or an error for a bad entry.
// ---------------------------------------------------------------------------
// Channel | Dir | Contents
// in_     | in  | tdata: page_rva, entry_word, current_value; tlast: last_in_block
// out_    | out | tdata: target_rva, new_value; tuser: write_width, status
// cfg_    | in  | data: base_delta (33 bits, signed)
//
// One word is accepted every cycle while out_tready does not stall; each
// result is registered through an input register and a result register.
// A high-adjust entry and its partner are two words giving one result.
// Reset is synchronous and clears the delta, the pending adjust and both stages.
// A stall on out_tready holds the result register and, through it, the input.
// ---------------------------------------------------------------------------
module base_relocation_fixup_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [79:0]     in_tdata,   // page_rva, entry_word, current_value
  input  logic            in_tlast,   // last_in_block
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [63:0]     out_tdata,  // target_rva, new_value
  output logic [3:0]      out_tuser,  // write_width, status
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  brf_pkg::delta_t cfg_data
);
  import brf_pkg::*;

  delta_t      delta_r;
  logic        s1_valid_r;
  logic [79:0] s1_data_r;
  logic        s1_last_r;
  logic        pending_r;
  logic [31:0] held_target_r;
  logic [15:0] held_value_r;
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [3:0]  out_user_r;

  logic        s2_free;
  logic        s1_adv;
  logic [31:0] page;
  logic [15:0] entry;
  logic [31:0] cur;
  rel_type_t   rtype;
  logic [31:0] target;
  logic [31:0] adj_sum;
  logic        res_valid;
  logic [31:0] res_target;
  logic [31:0] res_value;
  wr_width_t   res_width;
  status_t     res_status;
  logic        pending_nxt;
  logic        hold_en;

  assign s2_free   = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && s2_free;
  assign in_tready = !s1_valid_r || s2_free;
  assign cfg_ready = 1'b1;

  assign page   = s1_data_r[31:0];
  assign entry  = s1_data_r[47:32];
  assign cur    = s1_data_r[79:48];
  assign rtype  = rel_type_t'(entry >> TYPE_SHIFT);
  assign target = page + {20'h0, entry[11:0] & OFFSET_MASK};
  assign adj_sum = {held_value_r, 16'h0} + {{16{entry[15]}}, entry}
                 + delta_r[31:0] + ROUND_HALF;

  always_comb begin
    res_valid   = 1'b0;
    res_target  = target;
    res_value   = 32'h0;
    res_width   = WW_NONE;
    res_status  = ST_OK;
    pending_nxt = 1'b0;
    hold_en     = 1'b0;
    if (delta_r == '0) begin
      res_valid = 1'b0;
    end else if (pending_r) begin
      res_valid  = 1'b1;
      res_target = held_target_r;
      res_value  = {16'h0, adj_sum[31:16]};
      res_width  = WW_HALF;
    end else begin
      case (rtype)
        RT_ABSOLUTE: begin
          res_valid = 1'b0;
        end
        RT_HIGH: begin
          res_valid = 1'b1;
          res_value = {16'h0, cur[15:0] + delta_r[31:16]};
          res_width = WW_HALF;
        end
        RT_LOW: begin
          res_valid = 1'b1;
          res_value = {16'h0, cur[15:0] + delta_r[15:0]};
          res_width = WW_HALF;
        end
        RT_HIGHLOW: begin
          res_valid = 1'b1;
          res_value = cur + delta_r[31:0];
          res_width = WW_WORD;
        end
        RT_HIGHADJ: begin
          if (s1_last_r) begin
            res_valid  = 1'b1;
            res_status = ST_NO_PARTNER;
          end else begin
            pending_nxt = 1'b1;
            hold_en     = 1'b1;
          end
        end
        default: begin
          res_valid  = 1'b1;
          res_status = ST_UNKNOWN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r       <= '0;
      s1_valid_r    <= 1'b0;
      pending_r     <= 1'b0;
      held_target_r <= 32'h0;
      held_value_r  <= 16'h0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        delta_r <= cfg_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        pending_r <= pending_nxt;
        if (hold_en) begin
          held_target_r <= target;
          held_value_r  <= cur[15:0];
        end
      end
      if (s2_free) begin
        out_valid_r <= s1_valid_r && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_adv) begin
      out_data_r <= {res_value, res_target};
      out_user_r <= {res_status, res_width};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[rtl/brf_checker.sv]
// ---------------------------------------------------------------------------
// brf_checker
// Port-level checks on the relocation fixup core, bound into the core module.
// ---------------------------------------------------------------------------
`include "base_relocation_fixup_core_assert.svh"

module brf_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_tvalid,
  input logic            in_tready,
  input logic [79:0]     in_tdata,
  input logic            in_tlast,
  input logic            out_tvalid,
  input logic            out_tready,
  input logic [63:0]     out_tdata,
  input logic [3:0]      out_tuser,
  input logic            cfg_valid,
  input logic            cfg_ready,
  input brf_pkg::delta_t cfg_data
);
  import brf_pkg::*;

  logic      unused_ok;
  wr_width_t ww;
  status_t   st;

  assign unused_ok = in_tvalid ^ in_tready ^ in_tlast ^ cfg_valid ^ cfg_ready
                   ^ (^in_tdata) ^ (^cfg_data);
  assign ww = out_tuser[1:0];
  assign st = out_tuser[3:2];

  `BRF_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_tvalid, "result valid after reset")
  `BRF_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `BRF_ASSERT(a_err_no_write, clk, rst_n, out_tvalid && st != ST_OK |-> ww == WW_NONE && out_tdata[63:32] == 32'h0, "error result carries a write")
  `BRF_ASSERT(a_half_upper_zero, clk, rst_n, out_tvalid && ww == WW_HALF |-> out_tdata[63:48] == 16'h0, "halfword result has upper bits set")
  `BRF_ASSERT(a_ok_writes, clk, rst_n, out_tvalid && st == ST_OK |-> ww == WW_HALF || ww == WW_WORD, "ok result without a write")

endmodule

bind base_relocation_fixup_core brf_checker u_brf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_data   (cfg_data)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench for base_relocation_fixup_core
// Streams relocation entries through the core under several base deltas,
// with random gaps on both sides, and checks every patch word against a
// cycle-free prediction of the fixup rules.
// ---------------------------------------------------------------------------
module tb;
  import brf_pkg::*;

  typedef struct packed {
    logic [31:0] page_rva;
    logic [15:0] entry_word;
    logic [31:0] current_value;
    logic        last_in_block;
  } reloc_item_t;

  typedef struct packed {
    logic [31:0] target_rva;
    logic [31:0] new_value;
    wr_width_t   write_width;
    status_t     status;
  } patch_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  delta_t      cfg_data = '0;

  reloc_item_t entry_q[$];
  patch_t      patch_q[$];

  delta_t      delta_r = '0;
  logic        adj_pending = 1'b0;
  logic [31:0] adj_target = '0;
  logic [15:0] adj_value = '0;

  logic        in_took = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  int          cfg_writes = 0;
  int          fail_count = 0;
  reloc_item_t drv_item;
  patch_t      got;
  patch_t      want;

  base_relocation_fixup_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Applies one entry to the predicted state and queues the patch it causes.
  function automatic void fixup_entry(input reloc_item_t it);
    logic [63:0] d;
    logic [63:0] comb;
    logic [15:0] sum16;
    logic [31:0] target;
    rel_type_t   kind;
    patch_t      p;
    bit          emit;
    d = {{31{delta_r[32]}}, delta_r};
    kind = rel_type_t'(it.entry_word >> TYPE_SHIFT);
    target = it.page_rva + {20'd0, it.entry_word[11:0] & OFFSET_MASK};
    p = '0;
    p.target_rva = target;
    p.write_width = WW_HALF;
    p.status = ST_OK;
    emit = 1'b1;
    if (d == 64'd0) begin
      adj_pending = 1'b0;
      emit = 1'b0;
    end else if (adj_pending) begin
      comb = ({{48{adj_value[15]}}, adj_value} << 16)
           + {{48{it.entry_word[15]}}, it.entry_word} + d + {32'd0, ROUND_HALF};
      p.target_rva = adj_target;
      p.new_value = {16'd0, comb[31:16]};
      adj_pending = 1'b0;
    end else begin
      case (kind)
        RT_ABSOLUTE: emit = 1'b0;
        RT_HIGH: begin
          sum16 = it.current_value[15:0] + d[31:16];
          p.new_value = {16'd0, sum16};
        end
        RT_LOW: begin
          sum16 = it.current_value[15:0] + d[15:0];
          p.new_value = {16'd0, sum16};
        end
        RT_HIGHLOW: begin
          p.new_value = it.current_value + d[31:0];
          p.write_width = WW_WORD;
        end
        RT_HIGHADJ: begin
          if (it.last_in_block) begin
            p.write_width = WW_NONE;
            p.status = ST_NO_PARTNER;
          end else begin
            adj_pending = 1'b1;
            adj_target = target;
            adj_value = it.current_value[15:0];
            emit = 1'b0;
          end
        end
        default: begin
          p.write_width = WW_NONE;
          p.status = ST_UNKNOWN;
        end
      endcase
    end
    if (emit) patch_q.insert(patch_q.size(), p);
  endfunction

  // Register writes, entry acceptance and result checking, all at the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        delta_r = cfg_data;
        cfg_writes++;
      end
      in_took <= in_tvalid && in_tready;
      if (in_tvalid && in_tready)
        fixup_entry({in_tdata[31:0], in_tdata[47:32], in_tdata[79:48], in_tlast});
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[63:32], out_tuser[1:0], out_tuser[3:2]};
        if (patch_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = patch_q.pop_front();
          if (got.target_rva !== want.target_rva) begin
            $display("%0t target_rva mismatch: expected %h, actual %h",
                     $time, want.target_rva, got.target_rva);
            fail_count++;
          end
          if (got.new_value !== want.new_value) begin
            $display("%0t new_value mismatch: expected %h, actual %h",
                     $time, want.new_value, got.new_value);
            fail_count++;
          end
          if (got.write_width !== want.write_width) begin
            $display("%0t write_width mismatch: expected %0d, actual %0d",
                     $time, want.write_width, got.write_width);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            fail_count++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (entry_q.size() > 0) begin
        drv_item = entry_q.pop_front();
        in_tdata <= {drv_item.current_value, drv_item.entry_word, drv_item.page_rva};
        in_tlast <= drv_item.last_in_block;
        in_tvalid <= 1'b1;
        in_gap = pick_gap(in_idle_pct);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_stall = pick_gap(out_idle_pct);
    end
  end

  task automatic push_entry(input logic [31:0] page, input logic [15:0] entry,
                            input logic [31:0] cur, input logic last);
    entry_q.insert(entry_q.size(), {page, entry, cur, last});
  endtask

  task automatic set_delta(input delta_t value);
    int n;
    n = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(negedge clk); while (cfg_writes == n);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every expected patch has arrived; optionally closes a
  // high-adjust that is still waiting for its partner.
  task automatic drain(input bit close_adj);
    forever begin
      do @(posedge clk); while (entry_q.size() != 0 || in_tvalid || patch_q.size() != 0);
      repeat (8) @(posedge clk);
      if (!(close_adj && adj_pending)) break;
      push_entry($urandom, 16'($urandom_range(16'hffff)), $urandom,
                 1'($urandom_range(1)));
    end
  endtask

  task automatic gen_random(input int n);
    int          made;
    int          r;
    logic [11:0] offs;
    rel_type_t   kind;
    reloc_item_t it;
    made = 0;
    while (made < n) begin
      it.page_rva = $urandom;
      if ($urandom_range(9) == 0) it.page_rva = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
      it.current_value = $urandom;
      it.last_in_block = ($urandom_range(7) == 0);
      offs = 12'($urandom_range(4095));
      r = $urandom_range(99);
      if (r < 25) begin
        it.entry_word = {RT_HIGHADJ, offs};
        it.last_in_block = 1'b0;
        entry_q.insert(entry_q.size(), it);
        it.entry_word = 16'($urandom_range(16'hffff));
        it.last_in_block = 1'($urandom_range(1));
        entry_q.insert(entry_q.size(), it);
        made += 2;
      end else begin
        kind = (r < 80) ? rel_type_t'($urandom_range(4)) : rel_type_t'($urandom_range(15, 5));
        it.entry_word = {kind, offs};
        entry_q.insert(entry_q.size(), it);
        made++;
      end
    end
  endtask

  initial begin
    int     ph;
    delta_t d;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_delta(33'h0_1234_5678);
    push_entry(32'h0000_1000, {RT_ABSOLUTE, 12'h010}, 32'hdead_beef, 1'b0);
    push_entry(32'h0000_2000, {RT_HIGH, 12'h004}, 32'h0000_8fff, 1'b0);
    push_entry(32'h0000_2000, {RT_LOW, 12'h008}, 32'hffff_ffff, 1'b0);
    push_entry(32'hffff_ffff, {RT_HIGHLOW, 12'hfff}, 32'hffff_ffff, 1'b0);
    push_entry(32'h0000_0000, {RT_HIGHLOW, 12'h000}, 32'h0000_0000, 1'b1);
    push_entry(32'h0040_0000, {RT_HIGHADJ, 12'h100}, 32'h0000_7fff, 1'b0);
    push_entry(32'h1111_1111, 16'hffff, 32'h2222_2222, 1'b1);
    push_entry(32'h0040_0000, {RT_HIGHADJ, 12'h200}, 32'hffff_8000, 1'b0);
    push_entry(32'h0050_0000, {RT_HIGHADJ, 12'h800}, 32'h0000_0001, 1'b1);
    push_entry(32'h0040_0000, {RT_HIGHADJ, 12'h300}, 32'h0000_1234, 1'b1);
    push_entry(32'h0040_0000, {4'd5, 12'h123}, 32'h0, 1'b0);
    push_entry(32'h0040_0000, 16'hffff, 32'hffff_ffff, 1'b1);
    push_entry(32'h0060_0000, {RT_HIGHADJ, 12'h004}, 32'h0000_ffff, 1'b0);
    push_entry(32'h0070_0000, {RT_ABSOLUTE, 12'h000}, 32'h0, 1'b1);
    drain(1);

    set_delta(33'h1_ffff_ffff);
    push_entry(32'h0001_0000, {RT_HIGH, 12'h002}, 32'h0000_0000, 1'b0);
    push_entry(32'h0001_0000, {RT_LOW, 12'h004}, 32'h0000_0000, 1'b0);
    push_entry(32'h0001_0000, {RT_HIGHLOW, 12'h008}, 32'h0000_0000, 1'b1);
    push_entry(32'h0002_0000, {RT_HIGHADJ, 12'h010}, 32'h0000_0000, 1'b0);
    drain(0);

    // The pending high-adjust is dropped by the first entry under zero delta.
    set_delta(33'h0_0000_0000);
    push_entry(32'h0003_0000, {RT_HIGHLOW, 12'h020}, 32'h1234_5678, 1'b0);
    push_entry(32'h0003_0000, {4'd9, 12'h020}, 32'h1234_5678, 1'b0);
    push_entry(32'h0003_0000, {RT_HIGHADJ, 12'h020}, 32'h1234_5678, 1'b1);
    drain(0);
    set_delta(33'h0_0000_0100);
    push_entry(32'h0004_0000, {RT_HIGHLOW, 12'h040}, 32'h0000_ff00, 1'b1);
    drain(1);

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: d = 33'h0_0000_0001;
        1: d = 33'h1_ffff_ffff;
        2: d = 33'h0_ffff_ffff;
        3: d = 33'h1_0000_0001;
        4: d = 33'h0_0000_0000;
        5: d = 33'h0_0001_0000;
        default: begin
          d = {1'($urandom_range(1)), 32'($urandom)};
          if (d == 33'h1_0000_0000 || d == 33'h0) d = 33'h1_0000_0001;
        end
      endcase
      in_idle_pct = (ph % 3 == 0) ? 0 : 40;
      out_idle_pct = (ph % 4 == 1) ? 0 : 40;
      set_delta(d);
      gen_random(ph == 4 ? 100 : 215);
      drain(1);
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/brf_pkg.sv
rtl/base_relocation_fixup_core.sv
rtl/brf_checker.sv
verif/tb.sv
